// File: design/pee_pkg.sv
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared constants, item types, operation codes and state encodings.
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     stack_empty;
        logic                     underflow_seen;
        logic                     overflow_seen;
        logic                     divide_by_zero_seen;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POP
    } t_op_code;

    typedef struct packed {
        t_op_code   code;
        logic [3:0] digit;
        logic       last;
    } t_op;

    typedef enum logic [2:0] {
        B_IDLE,
        B_OPA,
        B_EXEC,
        B_DIV,
        B_REFILL,
        B_REFILL_WAIT,
        B_OUT
    } t_back_state;

endpackage

// File: design/pee_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/pee_front.sv
// ----------------------------------------------------------------------------
// Postfix evaluator front end
// Accepts characters, decodes them into operations and queues them.
// ----------------------------------------------------------------------------
module pee_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pee_pkg::t_in_item i_item,
    output logic              o_op_valid,
    input  logic              i_op_stall,
    output pee_pkg::t_op      o_op
);

    pee_pkg::t_op                r_mem [pee_pkg::QUEUE_DEPTH];
    logic [pee_pkg::QPTR_W-1:0]  r_wptr, n_wptr;
    logic [pee_pkg::QPTR_W-1:0]  r_rptr, n_rptr;
    logic [pee_pkg::QCNT_W-1:0]  r_cnt, n_cnt;
    pee_pkg::t_op                w_op;
    logic                        w_push, w_pop;

    always_comb begin
        w_op.last  = i_item.last;
        w_op.digit = 4'(i_item.symbol - pee_pkg::CH_ZERO);
        if (i_item.symbol >= pee_pkg::CH_ZERO && i_item.symbol <= pee_pkg::CH_NINE) begin
            w_op.code = pee_pkg::OP_DIGIT;
        end else if (i_item.symbol == pee_pkg::CH_ADD) begin
            w_op.code = pee_pkg::OP_ADD;
        end else if (i_item.symbol == pee_pkg::CH_SUB) begin
            w_op.code = pee_pkg::OP_SUB;
        end else if (i_item.symbol == pee_pkg::CH_MUL) begin
            w_op.code = pee_pkg::OP_MUL;
        end else if (i_item.symbol == pee_pkg::CH_DIV) begin
            w_op.code = pee_pkg::OP_DIV;
        end else begin
            w_op.code = pee_pkg::OP_POP;
        end
    end

    assign o_stall    = (r_cnt == pee_pkg::QCNT_W'(pee_pkg::QUEUE_DEPTH));
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_mem[r_rptr];
    assign w_push     = i_valid && !o_stall;
    assign w_pop      = o_op_valid && !i_op_stall;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wptr = (r_wptr == pee_pkg::QPTR_W'(pee_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == pee_pkg::QPTR_W'(pee_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_op;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// File: design/pee_div.sv
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Signed 32-bit division truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pee_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pee_pkg::DATA_W-1:0]  i_dividend,
    input  logic [pee_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pee_pkg::DATA_W-1:0]  o_quotient
);

    logic [pee_pkg::DATA_W-1:0]    r_rem, n_rem;
    logic [pee_pkg::DATA_W-1:0]    r_q, n_q;
    logic [pee_pkg::DATA_W-1:0]    r_d, n_d;
    logic                          r_neg, n_neg;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [pee_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [pee_pkg::DATA_W:0]      w_sh, w_diff;
    logic                          w_ge;

    assign w_sh   = {r_rem, r_q[pee_pkg::DATA_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_d});
    assign w_diff = w_sh - {1'b0, r_d};

    always_comb begin
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_dividend[pee_pkg::DATA_W-1] ? ('0 - i_dividend) : i_dividend;
            n_d    = i_divisor[pee_pkg::DATA_W-1] ? ('0 - i_divisor) : i_divisor;
            n_neg  = i_dividend[pee_pkg::DATA_W-1] ^ i_divisor[pee_pkg::DATA_W-1];
        end else if (r_busy) begin
            if (r_cnt == pee_pkg::DIV_CNT_W'(pee_pkg::DIV_STEPS)) begin
                n_q    = r_neg ? ('0 - r_q) : r_q;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_rem = w_ge ? w_diff[pee_pkg::DATA_W-1:0] : w_sh[pee_pkg::DATA_W-1:0];
                n_q   = {r_q[pee_pkg::DATA_W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
        r_neg <= n_neg;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: design/pee_back.sv
// ----------------------------------------------------------------------------
// Postfix evaluator back end
// Runs queued operations on the operand stack and registers the result.
// ----------------------------------------------------------------------------
module pee_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    output logic               o_op_stall,
    input  pee_pkg::t_op       i_op,
    output logic               o_valid,
    input  logic               i_stall,
    output pee_pkg::t_out_item o_result
);

    pee_pkg::t_back_state       r_state, n_state;
    logic [pee_pkg::CNT_W-1:0]  r_count, n_count;
    logic [pee_pkg::DATA_W-1:0] r_tos, n_tos;
    logic [pee_pkg::DATA_W-1:0] r_a, n_a;
    logic [pee_pkg::DATA_W-1:0] r_b, n_b;
    pee_pkg::t_op               r_op, n_op;
    logic                       r_under, n_under;
    logic                       r_over, n_over;
    logic                       r_divz, n_divz;
    logic                       r_out_valid, n_out_valid;
    pee_pkg::t_out_item         r_out, n_out;

    logic                       w_we;
    logic [pee_pkg::ADDR_W-1:0] w_waddr, w_raddr;
    logic [pee_pkg::DATA_W-1:0] w_rdata;
    logic                       w_div_start, w_div_done;
    logic [pee_pkg::DATA_W-1:0] w_a_val, w_quot;
    logic                       w_two, w_out_free;
    pee_pkg::t_back_state       w_finish;

    assign w_two      = (r_count >= pee_pkg::CNT_W'(2));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_a_val    = w_two ? w_rdata : '0;
    assign w_finish   = r_op.last ? pee_pkg::B_OUT : pee_pkg::B_IDLE;

    pee_ram #(
        .WIDTH (pee_pkg::DATA_W),
        .DEPTH (pee_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_tos),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_a_val),
        .i_divisor  (r_b),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pee_pkg::B_IDLE: begin
                if (i_op_valid) begin
                    if (i_op.code == pee_pkg::OP_DIGIT) begin
                        n_state = i_op.last ? pee_pkg::B_OUT : pee_pkg::B_IDLE;
                    end else begin
                        n_state = pee_pkg::B_OPA;
                    end
                end
            end
            pee_pkg::B_OPA: begin
                priority case (r_op.code)
                    pee_pkg::OP_ADD, pee_pkg::OP_SUB, pee_pkg::OP_MUL: n_state = pee_pkg::B_EXEC;
                    pee_pkg::OP_DIV: begin
                        n_state = (r_b != '0) ? pee_pkg::B_DIV : pee_pkg::B_REFILL;
                    end
                    default: n_state = pee_pkg::B_REFILL;
                endcase
            end
            pee_pkg::B_EXEC: n_state = w_finish;
            pee_pkg::B_DIV: begin
                if (w_div_done) begin
                    n_state = w_finish;
                end
            end
            pee_pkg::B_REFILL: begin
                n_state = (r_count != '0) ? pee_pkg::B_REFILL_WAIT : w_finish;
            end
            pee_pkg::B_REFILL_WAIT: n_state = w_finish;
            pee_pkg::B_OUT: begin
                if (w_out_free) begin
                    n_state = pee_pkg::B_IDLE;
                end
            end
            default: n_state = pee_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_tos       = r_tos;
        n_a         = r_a;
        n_b         = r_b;
        n_op        = r_op;
        n_under     = r_under;
        n_over      = r_over;
        n_divz      = r_divz;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        w_we        = 1'b0;
        w_waddr     = pee_pkg::ADDR_W'(r_count - 1'b1);
        w_raddr     = pee_pkg::ADDR_W'(r_count - pee_pkg::CNT_W'(2));
        w_div_start = 1'b0;
        o_op_stall  = (r_state != pee_pkg::B_IDLE);
        unique case (r_state)
            pee_pkg::B_IDLE: begin
                if (i_op_valid) begin
                    n_op = i_op;
                    if (i_op.code == pee_pkg::OP_DIGIT) begin
                        if (r_count == pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH)) begin
                            n_over = 1'b1;
                        end else begin
                            w_we    = (r_count != '0);
                            n_tos   = pee_pkg::DATA_W'(i_op.digit);
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_b = (r_count != '0) ? r_tos : '0;
                        if (!w_two) begin
                            n_under = 1'b1;
                        end
                    end
                end
            end
            pee_pkg::B_OPA: begin
                n_a     = w_a_val;
                n_count = w_two ? (r_count - pee_pkg::CNT_W'(2)) : '0;
                if (r_op.code == pee_pkg::OP_DIV) begin
                    if (r_b == '0) begin
                        n_divz = 1'b1;
                    end else begin
                        w_div_start = 1'b1;
                    end
                end
            end
            pee_pkg::B_EXEC: begin
                priority case (r_op.code)
                    pee_pkg::OP_ADD: n_tos = r_a + r_b;
                    pee_pkg::OP_SUB: n_tos = r_a - r_b;
                    default:         n_tos = r_a * r_b;
                endcase
                n_count = r_count + 1'b1;
            end
            pee_pkg::B_DIV: begin
                if (w_div_done) begin
                    n_tos   = w_quot;
                    n_count = r_count + 1'b1;
                end
            end
            pee_pkg::B_REFILL: begin
                w_raddr = pee_pkg::ADDR_W'(r_count - 1'b1);
            end
            pee_pkg::B_REFILL_WAIT: begin
                n_tos = w_rdata;
            end
            pee_pkg::B_OUT: begin
                if (w_out_free) begin
                    n_out_valid               = 1'b1;
                    n_out.value               = (r_count != '0) ? r_tos : '0;
                    n_out.stack_empty         = (r_count == '0);
                    n_out.underflow_seen      = r_under;
                    n_out.overflow_seen       = r_over;
                    n_out.divide_by_zero_seen = r_divz;
                    n_count                   = '0;
                    n_under                   = 1'b0;
                    n_over                    = 1'b0;
                    n_divz                    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        r_a   <= n_a;
        r_b   <= n_b;
        r_op  <= n_op;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= pee_pkg::B_IDLE;
            r_count     <= '0;
            r_under     <= 1'b0;
            r_over      <= 1'b0;
            r_divz      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_under     <= n_under;
            r_over      <= n_over;
            r_divz      <= n_divz;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: design/postfix_expression_evaluator.sv
// A digit is taken in the idle state; '+', '-' and '*' go through operand fetch and
// execute, an unknown character or a zero divisor through operand fetch and refill,
// and '/' through operand fetch and the iterative divider. The output state registers
// a result once the output is free; a two-entry queue lets input run ahead of the back end.
// Synchronous active-low reset empties the queue and the stack and clears the flags;
// the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates postfix expressions one character per request on an operand stack.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pee_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output pee_pkg::t_out_item o_result
);

    logic         w_op_valid;
    logic         w_op_stall;
    pee_pkg::t_op w_op;

    pee_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_op_valid (w_op_valid),
        .i_op_stall (w_op_stall),
        .o_op       (w_op)
    );

    pee_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .o_op_stall (w_op_stall),
        .i_op       (w_op),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result)
    );

endmodule

// File: design/pee_checker.sv
// ----------------------------------------------------------------------------
// Postfix evaluator checker
// Port-level assertions on reset behavior, request and result holding and
// result fields.
// ----------------------------------------------------------------------------
module pee_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input pee_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_stall,
    input pee_pkg::t_out_item o_result
);

    a_reset_no_result: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Result valid after reset.");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("Input stalled after reset.");

    a_request_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_item))
        else $error("Stalled request changed.");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("Stalled result changed.");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.stack_empty |-> o_result.value == '0)
        else $error("Empty stack result has a nonzero value.");

endmodule

bind postfix_expression_evaluator pee_checker u_checker (.*);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Postfix evaluator testbench
// Feeds expression characters through the request channel. A local stack
// calculator predicts each expression result, and every result is checked in
// order, field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned TARGET_ITEMS = 1400;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned PAUSE_EVERY  = 150;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_ALL_ONES = 8'hFF;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    pee_pkg::t_in_item  i_item = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    pee_pkg::t_out_item o_result;

    logic [pee_pkg::DATA_W-1:0] calc_stack [pee_pkg::STACK_DEPTH];
    int unsigned                calc_depth = 0;
    logic                       calc_under = 1'b0;
    logic                       calc_over = 1'b0;
    logic                       calc_divz = 1'b0;
    pee_pkg::t_out_item         pending_results[$];
    pee_pkg::t_out_item         oldest_result;
    int unsigned                mismatch_count = 0;
    int unsigned                items_sent = 0;
    int unsigned                cycle_count = 0;
    bit                         quiet_mode = 1'b0;

    postfix_expression_evaluator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= !quiet_mode && ($urandom_range(99) < 24);
    end

    function automatic void calc_push(input logic [pee_pkg::DATA_W-1:0] v);
        if (calc_depth >= pee_pkg::STACK_DEPTH) begin
            calc_over = 1'b1;
        end else begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    function automatic logic [pee_pkg::DATA_W-1:0] calc_pop();
        if (calc_depth == 0) begin
            calc_under = 1'b1;
            return '0;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    function automatic logic [pee_pkg::DATA_W-1:0] signed_quotient(
            input logic [pee_pkg::DATA_W-1:0] a,
            input logic [pee_pkg::DATA_W-1:0] b);
        logic [pee_pkg::DATA_W-1:0] mag_a;
        logic [pee_pkg::DATA_W-1:0] mag_b;
        logic [pee_pkg::DATA_W-1:0] q;
        mag_a = a[pee_pkg::DATA_W-1] ? -a : a;
        mag_b = b[pee_pkg::DATA_W-1] ? -b : b;
        q = mag_a / mag_b;
        return (a[pee_pkg::DATA_W-1] != b[pee_pkg::DATA_W-1]) ? -q : q;
    endfunction

    function automatic void evaluate_symbol(input pee_pkg::t_in_item it);
        logic [pee_pkg::DATA_W-1:0] a;
        logic [pee_pkg::DATA_W-1:0] b;
        pee_pkg::t_out_item         res;
        if (it.symbol >= pee_pkg::CH_ZERO && it.symbol <= pee_pkg::CH_NINE) begin
            calc_push({{(pee_pkg::DATA_W-8){1'b0}}, it.symbol - pee_pkg::CH_ZERO});
        end else begin
            b = calc_pop();
            a = calc_pop();
            case (it.symbol)
                pee_pkg::CH_ADD: calc_push(a + b);
                pee_pkg::CH_SUB: calc_push(a - b);
                pee_pkg::CH_MUL: calc_push(a * b);
                pee_pkg::CH_DIV: begin
                    if (b != '0) begin
                        calc_push(signed_quotient(a, b));
                    end else begin
                        calc_divz = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (it.last) begin
            res.stack_empty         = (calc_depth == 0);
            res.value               = (calc_depth == 0) ? '0 : calc_stack[calc_depth - 1];
            res.underflow_seen      = calc_under;
            res.overflow_seen       = calc_over;
            res.divide_by_zero_seen = calc_divz;
            pending_results.push_back(res);
            calc_depth = 0;
            calc_under = 1'b0;
            calc_over  = 1'b0;
            calc_divz  = 1'b0;
        end
    endfunction

    task automatic check_field(input string name, input logic [pee_pkg::DATA_W-1:0] want,
                               input logic [pee_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: value 0x%08h", o_result.value);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("value", oldest_result.value, o_result.value);
                check_field("stack_empty", oldest_result.stack_empty, o_result.stack_empty);
                check_field("underflow_seen", oldest_result.underflow_seen,
                            o_result.underflow_seen);
                check_field("overflow_seen", oldest_result.overflow_seen,
                            o_result.overflow_seen);
                check_field("divide_by_zero_seen", oldest_result.divide_by_zero_seen,
                            o_result.divide_by_zero_seen);
            end
        end
    end

    task automatic send_symbol(input logic [7:0] symbol, input logic last);
        pee_pkg::t_in_item item;
        item.symbol = symbol;
        item.last   = last;
        while (!quiet_mode && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_stall);
        evaluate_symbol(item);
        items_sent++;
    endtask

    task automatic send_sequence(input logic [7:0] symbols[$]);
        foreach (symbols[k]) begin
            send_symbol(symbols[k], k == symbols.size() - 1);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [7:0] digit_char(input int unsigned d);
        return pee_pkg::CH_ZERO + 8'(d);
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(3))
            0: return pee_pkg::CH_ADD;
            1: return pee_pkg::CH_SUB;
            2: return pee_pkg::CH_MUL;
            default: return pee_pkg::CH_DIV;
        endcase
    endfunction

    task automatic send_random_expression(input int unsigned operands);
        logic [7:0]  symbols[$];
        int unsigned depth;
        int unsigned pushed;
        depth  = 0;
        pushed = 0;
        while (pushed < operands || depth > 1) begin
            if (pushed < operands && (depth < 2 || $urandom_range(1) == 1)) begin
                symbols.push_back(digit_char($urandom_range(9)));
                depth++;
                pushed++;
            end else begin
                symbols.push_back(random_operator());
                depth--;
            end
        end
        send_sequence(symbols);
    endtask

    task automatic send_broken_sequence();
        logic [7:0]  symbols[$];
        int unsigned n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(2))
                0: symbols.push_back(digit_char($urandom_range(9)));
                1: symbols.push_back(random_operator());
                default: symbols.push_back(8'($urandom_range(255)));
            endcase
        end
        send_sequence(symbols);
    endtask

    task automatic test_digit_extremes();
        send_symbol(pee_pkg::CH_ZERO, 1'b1);
        send_symbol(pee_pkg::CH_NINE, 1'b1);
    endtask

    task automatic test_arithmetic();
        send_sequence({digit_char(8), digit_char(3), pee_pkg::CH_ADD});
        send_sequence({digit_char(2), digit_char(7), pee_pkg::CH_SUB, digit_char(2),
                       pee_pkg::CH_DIV});
        send_sequence({digit_char(9), digit_char(6), pee_pkg::CH_MUL});
    endtask

    task automatic test_error_flags();
        send_symbol(pee_pkg::CH_ADD, 1'b1);
        send_sequence({digit_char(7), pee_pkg::CH_SUB});
        send_sequence({digit_char(5), digit_char(0), pee_pkg::CH_DIV});
        send_sequence({digit_char(5), digit_char(6), CH_ALL_ONES});
        send_symbol(CH_NUL, 1'b1);
    endtask

    task automatic test_most_negative_quotient();
        logic [7:0] symbols[$];
        symbols.push_back(digit_char(2));
        repeat (10) begin
            symbols.push_back(digit_char(8));
            symbols.push_back(pee_pkg::CH_MUL);
        end
        symbols.push_back(digit_char(0));
        symbols.push_back(digit_char(1));
        symbols.push_back(pee_pkg::CH_SUB);
        symbols.push_back(pee_pkg::CH_DIV);
        send_sequence(symbols);
    endtask

    task automatic test_stack_extremes();
        logic [7:0] symbols[$];
        repeat (pee_pkg::STACK_DEPTH) symbols.push_back(digit_char($urandom_range(9)));
        repeat (pee_pkg::STACK_DEPTH - 1) symbols.push_back(random_operator());
        send_sequence(symbols);
        symbols.delete();
        repeat (pee_pkg::STACK_DEPTH + 2) symbols.push_back(digit_char($urandom_range(9)));
        send_sequence(symbols);
    endtask

    task automatic test_random_traffic();
        int unsigned last_pause;
        last_pause = items_sent;
        while (items_sent < TARGET_ITEMS) begin
            quiet_mode = (items_sent >= 700 && items_sent < 950);
            case ($urandom_range(19))
                0: send_broken_sequence();
                1: repeat ($urandom_range(1, 4)) begin
                    send_symbol(8'($urandom_range(255)), $urandom_range(3) == 0);
                end
                2, 3: send_random_expression($urandom_range(8, 14));
                default: send_random_expression($urandom_range(1, 6));
            endcase
            if (items_sent - last_pause >= PAUSE_EVERY) begin
                wait_for_results();
                last_pause = items_sent;
            end
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_digit_extremes();
        test_arithmetic();
        test_error_flags();
        test_most_negative_quotient();
        test_stack_extremes();
        test_random_traffic();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
